// ----- hdl/lrpw_pkg.sv -----
// ============================================================================
// lrpw_pkg - shared definitions for the regular Loop patch weight pipeline
// Widths, monomial and coefficient tables, and pipeline control types.
// ============================================================================
package lrpw_pkg;

    localparam int COORD_W     = 17;              // Q1.16 coordinate
    localparam int HALF_W      = 17;              // split point of a square
    localparam int SQ_W        = 2 * COORD_W;     // degree-2 product
    localparam int PP_W        = 2 * HALF_W;      // one partial product
    localparam int MONO_W      = 4 * COORD_W;     // degree-4 monomial, Q4.64
    localparam int COEF_W      = 6;
    localparam int ACC_W       = MONO_W + 9;      // coefficient sums stay below 512
    localparam int WEIGHT_W    = 20;              // Q4.16 result
    localparam int FRAC_SHIFT  = 48;              // Q4.64 -> Q4.16

    localparam int NUM_SQ      = 6;
    localparam int NUM_MONO    = 15;
    localparam int NUM_WEIGHTS = 12;
    localparam int NUM_PP      = 4;
    localparam int GROUP_SIZE  = 5;
    localparam int NUM_GROUPS  = NUM_MONO / GROUP_SIZE;
    localparam int NUM_STAGES  = 5;

    localparam int IN_TDATA_W  = ((3 * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_WEIGHTS * WEIGHT_W + 7) / 8) * 8;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    // partial product slots of one 34 x 34 product
    localparam int PP_LL = 0;
    localparam int PP_LH = 1;
    localparam int PP_HL = 2;
    localparam int PP_HH = 3;

    typedef logic [COORD_W-1:0]                     coord_t;
    typedef logic [NUM_MONO-1:0][MONO_W-1:0]        mono_vec_t;
    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0]   weight_vec_t;

    // degree-2 products
    typedef enum logic [2:0] {
        SQ_UU,
        SQ_UV,
        SQ_UW,
        SQ_VV,
        SQ_VW,
        SQ_WW
    } sq_sel_t;

    // monomial order: u4 u3v u3w u2v2 u2vw u2w2 uv3 uv2w uvw2 uw3 v4 v3w v2w2 vw3 w4
    localparam sq_sel_t MONO_A [NUM_MONO] = '{
        SQ_UU, SQ_UU, SQ_UU, SQ_UU, SQ_UU, SQ_UU, SQ_UV, SQ_UV,
        SQ_UV, SQ_UW, SQ_VV, SQ_VV, SQ_VV, SQ_VW, SQ_WW
    };
    localparam sq_sel_t MONO_B [NUM_MONO] = '{
        SQ_UU, SQ_UV, SQ_UW, SQ_VV, SQ_VW, SQ_WW, SQ_VV, SQ_VW,
        SQ_WW, SQ_WW, SQ_VV, SQ_VW, SQ_WW, SQ_WW, SQ_WW
    };

    // box-spline coefficients, one row per weight, columns in monomial order
    localparam logic [COEF_W-1:0] COEF [NUM_WEIGHTS][NUM_MONO] = '{
        '{ 1,  2,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0},
        '{ 1,  0,  2,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0},
        '{ 1,  6,  2, 12,  6,  0,  6,  6,  0,  0,  1,  2,  0,  0,  0},
        '{ 6, 24, 24, 24, 60, 24,  8, 36, 36,  8,  1,  6, 12,  6,  1},
        '{ 1,  2,  6,  0,  6, 12,  0,  0,  6,  6,  0,  0,  0,  2,  1},
        '{ 0,  0,  0,  0,  0,  0,  2,  0,  0,  0,  1,  0,  0,  0,  0},
        '{ 1,  8,  6, 24, 36, 12, 24, 60, 36,  6,  6, 24, 24,  8,  1},
        '{ 1,  6,  8, 12, 36, 24,  6, 36, 60, 24,  1,  8, 24, 24,  6},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  2,  0,  0,  0,  0,  1},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  1,  2,  0,  0,  0},
        '{ 0,  0,  0,  0,  0,  0,  2,  6,  6,  2,  1,  6, 12,  6,  1},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  2,  1}
    };

    // stage numbering of the valid pipeline
    localparam int STG_SQ   = 0;
    localparam int STG_PP   = 1;
    localparam int STG_MONO = 2;
    localparam int STG_PART = 3;
    localparam int STG_OUT  = 4;

    typedef struct packed {
        logic sq;
        logic pp;
        logic mono;
    } mono_en_t;

    typedef struct packed {
        logic part;
        logic out;
    } comb_en_t;

endpackage

// ----- hdl/lrpw_mono.sv -----
// ============================================================================
// lrpw_mono - degree-four monomial generator
// Three register stages: squares, 17x17 partial products, assembled monomials.
// ============================================================================
module lrpw_mono
(
    input  logic                clk,
    input  lrpw_pkg::coord_t    bary_u,
    input  lrpw_pkg::coord_t    bary_v,
    input  lrpw_pkg::coord_t    bary_w,
    input  lrpw_pkg::mono_en_t  en,
    output lrpw_pkg::mono_vec_t mono
);
    import lrpw_pkg::*;

    logic [NUM_SQ-1:0][SQ_W-1:0]                 sq_reg, sq_next;
    logic [NUM_MONO-1:0][NUM_PP-1:0][PP_W-1:0]   pp_reg, pp_next;
    mono_vec_t                                   mono_reg, mono_next;

    always_comb
    begin
        sq_next[SQ_UU] = bary_u * bary_u;
        sq_next[SQ_UV] = bary_u * bary_v;
        sq_next[SQ_UW] = bary_u * bary_w;
        sq_next[SQ_VV] = bary_v * bary_v;
        sq_next[SQ_VW] = bary_v * bary_w;
        sq_next[SQ_WW] = bary_w * bary_w;
    end

    // split each square product into 17-bit halves
    always_comb
    begin
        logic [SQ_W-1:0] op_a;
        logic [SQ_W-1:0] op_b;
        for (int m = 0; m < NUM_MONO; m++)
        begin
            op_a = sq_reg[MONO_A[m]];
            op_b = sq_reg[MONO_B[m]];
            pp_next[m][PP_LL] = op_a[HALF_W-1:0] * op_b[HALF_W-1:0];
            pp_next[m][PP_LH] = op_a[HALF_W-1:0] * op_b[SQ_W-1:HALF_W];
            pp_next[m][PP_HL] = op_a[SQ_W-1:HALF_W] * op_b[HALF_W-1:0];
            pp_next[m][PP_HH] = op_a[SQ_W-1:HALF_W] * op_b[SQ_W-1:HALF_W];
        end
    end

    always_comb
    begin
        for (int m = 0; m < NUM_MONO; m++)
        begin
            mono_next[m] = (MONO_W'(pp_reg[m][PP_HH]) << (2 * HALF_W))
                         + ((MONO_W'(pp_reg[m][PP_HL]) + MONO_W'(pp_reg[m][PP_LH]))
                            << HALF_W)
                         + MONO_W'(pp_reg[m][PP_LL]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sq)
        begin
            sq_reg <= sq_next;
        end
        if (en.pp)
        begin
            pp_reg <= pp_next;
        end
        if (en.mono)
        begin
            mono_reg <= mono_next;
        end
    end

    assign mono = mono_reg;

endmodule

// ----- hdl/lrpw_combine.sv -----
// ============================================================================
// lrpw_combine - weighted monomial sums
// Two register stages: group sums per weight, then final sum and saturation.
// ============================================================================
module lrpw_combine
(
    input  logic                  clk,
    input  lrpw_pkg::mono_vec_t   mono,
    input  lrpw_pkg::comb_en_t    en,
    output lrpw_pkg::weight_vec_t weight
);
    import lrpw_pkg::*;

    logic [NUM_WEIGHTS-1:0][NUM_GROUPS-1:0][ACC_W-1:0] part_reg, part_next;
    weight_vec_t                                       weight_reg, weight_next;

    // coefficients are constants: each product reduces to a few shifted adds
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                acc = '0;
                for (int j = 0; j < GROUP_SIZE; j++)
                begin
                    acc = acc + ACC_W'(COEF[k][g * GROUP_SIZE + j])
                              * ACC_W'(mono[g * GROUP_SIZE + j]);
                end
                part_next[k][g] = acc;
            end
        end
    end

    // add the group sums, truncate to Q4.16, clamp on overflow
    always_comb
    begin
        logic [ACC_W-1:0] total;
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            total = '0;
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                total = total + part_reg[k][g];
            end
            if (total[ACC_W-1:MONO_W] != '0)
            begin
                weight_next[k] = WEIGHT_MAX;
            end
            else
            begin
                weight_next[k] = total[MONO_W-1:FRAC_SHIFT];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            part_reg <= part_next;
        end
        if (en.out)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

// ----- hdl/loop_regular_patch_weights_top.sv -----
// ============================================================================
// loop_regular_patch_weights_top - regular Loop patch basis weights
// Streams barycentric triples in, twelve quartic box-spline weights out.
// ============================================================================
// One transfer on the slave side carries a triple (u, v, w) in Q1.16; it
// passes through the square, partial product, monomial and group sum
// registers before the output register loads the twelve weights of the
// regular Loop patch in Q4.16, saturating at the largest code. From then on
// the master side offers them. The factor 1/12 is not applied, so the
// weights add up to 12.0 when u + v + w is 1.0. Inputs are not checked or
// renormalized, and every coordinate up to 131071 is evaluated as given.
// The pipeline takes one triple per clock cycle when the master side keeps
// tready high: the five register stages (squares, partial products,
// monomials, group sums, final sum with saturation) each hold one triple.
// When the master side stalls, the stages ahead of the stalled result keep
// filling, so bubbles close up before s_axis_tready drops. No state is kept
// between triples.
module loop_regular_patch_weights_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bary_u [16:0], bary_v [33:17], bary_w [50:34], zero [55:51]
    input  logic [lrpw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // weight_0 [19:0], weight_1 [39:20], ... weight_11 [239:220]
    output logic [lrpw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lrpw_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] stage_in_valid;
    logic [NUM_STAGES-1:0] stage_load;

    coord_t      bary_u, bary_v, bary_w;
    mono_en_t    mono_en;
    comb_en_t    comb_en;
    mono_vec_t   mono;
    weight_vec_t weight;

    // unpack the input transfer
    assign bary_u = s_axis_tdata[COORD_W-1:0];
    assign bary_v = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign bary_w = s_axis_tdata[3*COORD_W-1:2*COORD_W];

    // a stage may load when it is empty or its content moves on this cycle
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end

        stage_in_valid[0] = s_axis_tvalid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            stage_in_valid[i] = valid_reg[i-1];
        end

        for (int i = 0; i < NUM_STAGES; i++)
        begin
            // load only real items; advance the valid bit on every ready cycle
            stage_load[i] = stage_ready[i] && stage_in_valid[i];
            valid_next[i] = stage_ready[i] ? stage_in_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign mono_en.sq   = stage_load[STG_SQ];
    assign mono_en.pp   = stage_load[STG_PP];
    assign mono_en.mono = stage_load[STG_MONO];
    assign comb_en.part = stage_load[STG_PART];
    assign comb_en.out  = stage_load[STG_OUT];

    // squares -> partial products -> monomials
    lrpw_mono u_mono
    (
        .clk    (clk),
        .bary_u (bary_u),
        .bary_v (bary_v),
        .bary_w (bary_w),
        .en     (mono_en),
        .mono   (mono)
    );

    // group sums -> final sum, truncate and saturate; holds the output
    lrpw_combine u_combine
    (
        .clk    (clk),
        .mono   (mono),
        .en     (comb_en),
        .weight (weight)
    );

    assign s_axis_tready = stage_ready[STG_SQ];
    assign m_axis_tvalid = valid_reg[STG_OUT];
    assign m_axis_tdata  = weight;

endmodule

// ----- dv/loop_regular_patch_weights_top_tb.sv -----
// ============================================================================
// loop_regular_patch_weights_top_tb - regular Loop patch weight stream check
// Feeds barycentric triples through the slave stream and checks every set of
// twelve Q4.16 box-spline weights against an exact 128-bit evaluation of the
// basis polynomials, with random gaps and stalls on both streams.
// ============================================================================
`timescale 1ns / 100ps

module loop_regular_patch_weights_top_tb;

    import lrpw_pkg::*;

    localparam int RANDOM_TRIPLES = 1000;
    localparam int CALM_TAIL      = 150;   // last triples sent with no gaps or stalls
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT    = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES   = 20;    // idle wait after the last result is checked

    // Monomial exponents, order: u4 u3v u3w u2v2 u2vw u2w2 uv3 uv2w uvw2 uw3
    // v4 v3w v2w2 vw3 w4
    localparam int EXP_U [15] = '{4, 3, 3, 2, 2, 2, 1, 1, 1, 1, 0, 0, 0, 0, 0};
    localparam int EXP_V [15] = '{0, 1, 0, 2, 1, 0, 3, 2, 1, 0, 4, 3, 2, 1, 0};
    localparam int EXP_W [15] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3, 0, 1, 2, 3, 4};

    // Unscaled quartic box-spline basis of the regular Loop patch; one row per
    // weight, one column per monomial in the order above.
    localparam int BOX_COEF [12][15] = '{
        '{ 1,  2,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0},
        '{ 1,  0,  2,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0},
        '{ 1,  6,  2, 12,  6,  0,  6,  6,  0,  0,  1,  2,  0,  0,  0},
        '{ 6, 24, 24, 24, 60, 24,  8, 36, 36,  8,  1,  6, 12,  6,  1},
        '{ 1,  2,  6,  0,  6, 12,  0,  0,  6,  6,  0,  0,  0,  2,  1},
        '{ 0,  0,  0,  0,  0,  0,  2,  0,  0,  0,  1,  0,  0,  0,  0},
        '{ 1,  8,  6, 24, 36, 12, 24, 60, 36,  6,  6, 24, 24,  8,  1},
        '{ 1,  6,  8, 12, 36, 24,  6, 36, 60, 24,  1,  8, 24, 24,  6},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  2,  0,  0,  0,  0,  1},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  1,  2,  0,  0,  0},
        '{ 0,  0,  0,  0,  0,  0,  2,  6,  6,  2,  1,  6, 12,  6,  1},
        '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  2,  1}
    };

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the weights of each accepted triple and compares
    // them, in order, with the weights leaving the master stream.
    // ------------------------------------------------------------------------
    class patch_weight_board;

        typedef struct {
            coord_t      u;
            coord_t      v;
            coord_t      w;
            weight_vec_t wts;
        } patch_sample_t;

        patch_sample_t outstanding[$];
        int            mismatches;
        int            results_seen;
        int            saturated;

        // Evaluate every monomial exactly in Q4.64, sum per weight, then
        // truncate to Q4.16 and clamp anything at or above 16.0.
        function weight_vec_t box_spline_weights(coord_t u, coord_t v, coord_t w);
            logic [127:0] pu [5];
            logic [127:0] pv [5];
            logic [127:0] pw [5];
            logic [127:0] acc;
            weight_vec_t  wts;
            pu[0] = 128'd1;
            pv[0] = 128'd1;
            pw[0] = 128'd1;
            for (int i = 1; i < 5; i++)
            begin
                pu[i] = pu[i-1] * 128'(u);
                pv[i] = pv[i-1] * 128'(v);
                pw[i] = pw[i-1] * 128'(w);
            end
            for (int k = 0; k < NUM_WEIGHTS; k++)
            begin
                acc = '0;
                for (int m = 0; m < 15; m++)
                    acc += 128'(BOX_COEF[k][m]) * pu[EXP_U[m]] * pv[EXP_V[m]] * pw[EXP_W[m]];
                if (acc[127:68] != '0)
                    wts[k] = WEIGHT_MAX;
                else
                    wts[k] = acc[67:48];
            end
            return wts;
        endfunction

        function void note_triple(coord_t u, coord_t v, coord_t w);
            patch_sample_t s;
            s.u   = u;
            s.v   = v;
            s.w   = w;
            s.wts = box_spline_weights(u, v, w);
            for (int k = 0; k < NUM_WEIGHTS; k++)
                if (s.wts[k] == WEIGHT_MAX)
                    saturated++;
            outstanding = {outstanding, s};
        endfunction

        function void check_weights(logic [OUT_TDATA_W-1:0] tdata);
            patch_sample_t s;
            weight_vec_t   got;
            got = weight_vec_t'(tdata[NUM_WEIGHTS*WEIGHT_W-1:0]);
            results_seen++;
            if (outstanding.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no triple outstanding: expected none, got %h",
                         $time, got);
                return;
            end
            s = outstanding.pop_front();
            for (int k = 0; k < NUM_WEIGHTS; k++)
                if (got[k] !== s.wts[k])
                begin
                    mismatches++;
                    $display("%0t: weight_%0d for u=%0d v=%0d w=%0d: expected %0d, got %0d",
                             $time, k, s.u, s.v, s.w, s.wts[k], got[k]);
                end
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    patch_weight_board board = new();

    bit sender_bursts;     // random gaps between triples on the slave side
    bit receiver_bursts;   // random stalls on the master side
    bit hold_req;          // ask the receiver for one long hold-off
    int triples_in;
    int quiet_cycles;

    loop_regular_patch_weights_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sample both streams at the rising edge; note the input before checking
    // the output so a same-edge pair is always in order.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            board.note_triple(coord_t'(s_axis_tdata[COORD_W-1:0]),
                              coord_t'(s_axis_tdata[2*COORD_W-1:COORD_W]),
                              coord_t'(s_axis_tdata[3*COORD_W-1:2*COORD_W]));
            triples_in++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_weights(m_axis_tdata);
    end

    // Watchdog: end the run when neither stream has moved for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d triples still pending",
                         $time, quiet_cycles, board.pending());
                $display("FAIL loop_regular_patch_weights_top");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // pipeline fills and the slave side backs up.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req      = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (receiver_bursts && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Offer one triple from a falling edge and hold it until a transfer.
    task automatic send_triple(coord_t u, coord_t v, coord_t w);
        if (sender_bursts && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tdata  = IN_TDATA_W'({w, v, u});
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Mostly unit-sum triples in a random rotation; the rest unrestricted codes,
    // sums at or just above one, and a mix of boundary codes.
    task automatic send_random_triple();
        coord_t c [3];
        int     a;
        int     b;
        int     rot;
        int     kind;
        int     edge_codes [6];
        edge_codes = '{0, 1, 65535, 65536, 65537, 131071};
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            a    = $urandom_range(0, 65536);
            b    = $urandom_range(0, 65536 - a);
            c[0] = coord_t'(a);
            c[1] = coord_t'(b);
            c[2] = coord_t'(65536 - a - b);
        end
        else if (kind <= 7)
        begin
            for (int i = 0; i < 3; i++)
                c[i] = coord_t'($urandom_range(0, 131071));
        end
        else if (kind == 8)
        begin
            a    = $urandom_range(0, 65536);
            b    = $urandom_range(0, 65536 - a);
            c[0] = coord_t'(a);
            c[1] = coord_t'(b);
            c[2] = coord_t'(65536 - a - b + $urandom_range(0, 64));
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                c[i] = coord_t'(edge_codes[$urandom_range(0, 5)]);
        end
        rot = $urandom_range(0, 2);
        send_triple(c[rot], c[(rot + 1) % 3], c[(rot + 2) % 3]);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        sender_bursts   = 1'b1;
        receiver_bursts = 1'b1;
        hold_req        = 1'b0;
        triples_in      = 0;
        quiet_cycles    = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: corners, edges, center, over-range and saturating inputs.
        send_triple(17'd0,      17'd0,      17'd0);
        send_triple(17'd65536,  17'd0,      17'd0);
        send_triple(17'd0,      17'd65536,  17'd0);
        send_triple(17'd0,      17'd0,      17'd65536);
        send_triple(17'd32768,  17'd32768,  17'd0);
        send_triple(17'd32768,  17'd0,      17'd32768);
        send_triple(17'd0,      17'd32768,  17'd32768);
        send_triple(17'd21845,  17'd21845,  17'd21846);
        send_triple(17'd65535,  17'd1,      17'd0);
        send_triple(17'd1,      17'd1,      17'd65534);
        send_triple(17'd1,      17'd1,      17'd1);
        send_triple(17'd131071, 17'd0,      17'd0);
        send_triple(17'd0,      17'd131071, 17'd0);
        send_triple(17'd0,      17'd0,      17'd131071);
        send_triple(17'd65536,  17'd65536,  17'd65536);
        send_triple(17'd131071, 17'd131071, 17'd131071);
        send_triple(17'h15555,  17'h0AAAA,  17'h15555);
        send_triple(17'h0AAAA,  17'h15555,  17'h0AAAA);
        send_triple(17'd98304,  17'd16384,  17'd0);
        send_triple(17'd0,      17'd98304,  17'd98304);

        for (int i = 0; i < 400; i++)
            send_random_triple();

        // Pause the sender until the pipeline has fully drained.
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat ($urandom_range(1, 8)) @(negedge clk);

        // Keep offering back to back while the receiver holds off.
        sender_bursts = 1'b0;
        hold_req      = 1'b1;
        for (int i = 0; i < 60; i++)
            send_random_triple();
        sender_bursts = 1'b1;

        for (int i = 460; i < RANDOM_TRIPLES; i++)
        begin
            if (i == RANDOM_TRIPLES - CALM_TAIL)
            begin
                sender_bursts   = 1'b0;
                receiver_bursts = 1'b0;
            end
            send_random_triple();
        end
        s_axis_tvalid = 1'b0;

        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d triples (corners, over-range, unit-sum and unrestricted random)",
                 triples_in);
        $display("Checked %0d weight sets, %0d saturated weights, %0d mismatches",
                 board.results_seen, board.saturated, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS loop_regular_patch_weights_top");
        else
            $display("FAIL loop_regular_patch_weights_top");
        $finish;
    end

endmodule
